[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/csw_pkg.sv]
// ----------------------------------------------------------------------------
// csw_pkg
// Types and constants of the counting semaphore with a FIFO wait queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csw_pkg;

  // Field widths
  localparam int TASK_ID_WIDTH = 8;
  localparam int REG_W         = 15;
  localparam int COUNT_W       = 17;
  localparam int OUT_COUNT_W   = 16;
  localparam int CFG_IDX_W     = 1;

  // Default number of wait queue entries
  localparam int WAIT_DEPTH = 16;

  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_COUNT     = 1'b0,
    CFG_INITIAL_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e                      op;
    logic [TASK_ID_WIDTH-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    status_e                        status;
    logic                           wake_valid;
    logic [TASK_ID_WIDTH-1:0]       wake_task;
    logic signed [OUT_COUNT_W-1:0]  count_after;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[sv/csw_ctrl.sv]
// ----------------------------------------------------------------------------
// csw_ctrl
// Sequencer: takes one item, then commits it once the result register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csw_pkg::dp_status_t   status_i,
  output csw_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.commit   = 1'b0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/csw_dp.sv]
// ----------------------------------------------------------------------------
// csw_dp
// Datapath: count, config registers, wait queue memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csw_dp #(
  parameter int WAIT_DEPTH = csw_pkg::WAIT_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csw_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output csw_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_we_i,
  input  logic [csw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csw_pkg::REG_W-1:0]           cfg_wdata_i,
  input  csw_pkg::ctrl_cmd_t                  cmd_i,
  output csw_pkg::dp_status_t                 status_o
);

  localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * WAIT_DEPTH);
  localparam int TW     = csw_pkg::TASK_ID_WIDTH;
  localparam int CW     = csw_pkg::COUNT_W;
  localparam int RW     = csw_pkg::REG_W;

  // Config register; the initial count goes straight into the count
  logic [RW-1:0] max_q;

  // Semaphore state
  logic signed [CW-1:0] count_q, count_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [FILL_W-1:0]    fill_q, fill_d;

  // Captured item
  csw_pkg::op_e    op_q;
  logic [TW-1:0]   tid_q;

  // Wait queue and its registered head read
  logic [TW-1:0]   wait_mem [WAIT_DEPTH];
  logic [TW-1:0]   head_rd_q;

  // Result register
  logic                 out_valid_q;
  csw_pkg::out_item_t   out_item_q, result;

  logic                 push;
  logic [PTR_W-1:0]     push_slot;
  logic [SUM_W-1:0]     slot_sum;
  logic                 deficit;
  logic                 below_max;
  logic                 queue_full;
  logic                 init_wr;

  assign init_wr = cfg_we_i && (cfg_index_i == csw_pkg::CFG_INITIAL_COUNT);

  // Tail slot: head + fill wraps at most once
  always_comb begin
    slot_sum = SUM_W'(head_q) + SUM_W'(fill_q);
    if (slot_sum >= SUM_W'(WAIT_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(WAIT_DEPTH);
    end
  end
  assign push_slot = slot_sum[PTR_W-1:0];

  assign deficit    = (count_q < $signed(CW'(1)));
  assign below_max  = (count_q < $signed({{(CW-RW){1'b0}}, max_q}));
  assign queue_full = (fill_q == FILL_W'(WAIT_DEPTH));

  // Operation
  always_comb begin
    count_d            = count_q;
    head_d             = head_q;
    fill_d             = fill_q;
    push               = 1'b0;
    result.status      = csw_pkg::ST_GRANTED;
    result.wake_valid  = 1'b0;
    result.wake_task   = '0;
    unique case (op_q)
      csw_pkg::OP_ACQUIRE: begin
        if (!deficit) begin
          count_d       = count_q - CW'(1);
          result.status = csw_pkg::ST_GRANTED;
        end else if (queue_full) begin
          result.status = csw_pkg::ST_FULL;
        end else begin
          count_d       = count_q - CW'(1);
          fill_d        = fill_q + FILL_W'(1);
          push          = 1'b1;
          result.status = csw_pkg::ST_BLOCKED;
        end
      end
      csw_pkg::OP_RELEASE: begin
        if (below_max) begin
          count_d       = count_q + CW'(1);
          result.status = csw_pkg::ST_RELEASED;
          // New count at or below zero: wake the oldest waiter
          if (count_q[CW-1] && (fill_q != '0)) begin
            result.wake_valid = 1'b1;
            result.wake_task  = head_rd_q;
            fill_d            = fill_q - FILL_W'(1);
            head_d            = (head_q == PTR_W'(WAIT_DEPTH - 1)) ? '0
                                                                   : head_q + PTR_W'(1);
          end
        end else begin
          result.status = csw_pkg::ST_IGNORED;
        end
      end
      default: begin
        result.status = csw_pkg::ST_GRANTED;
      end
    endcase
    result.count_after = count_d[csw_pkg::OUT_COUNT_W-1:0];
  end

  // Config and semaphore state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= RW'(1);
      count_q <= CW'(1);
      head_q  <= '0;
      fill_q  <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == csw_pkg::CFG_MAX_COUNT)) begin
        max_q <= cfg_wdata_i;
      end
      if (init_wr) begin
        count_q <= {{(CW-RW){1'b0}}, cfg_wdata_i};
        head_q  <= '0;
        fill_q  <= '0;
      end else if (cmd_i.commit) begin
        count_q <= count_d;
        head_q  <= head_d;
        fill_q  <= fill_d;
      end
    end
  end

  // Captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_item_i.op;
      tid_q <= in_item_i.task_id;
    end
  end

  // Wait queue memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && push) begin
      wait_mem[push_slot] <= tid_q;
    end
    head_rd_q <= wait_mem[head_q];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_item_q <= result;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;

endmodule

[sv/counting_semaphore_wait_queue.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO queue of blocked task ids.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------
//   in      | in  | in_valid_i/in_stall_o  | op, task_id
//   out     | out | out_valid_o/out_stall_i| status, wake, count_after
//   cfg     | in  | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// Each item is registered in S_IDLE; in S_EXEC it updates the count and the
// queue and loads the result register; the queue head is read from a
// registered memory port while the block waits for the item.
// Reset loads the count with initial_count (1) and empties the queue.
// An item is taken while the previous result still waits; the second one
// holds in its update cycle until the result register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module counting_semaphore_wait_queue #(
  parameter int WAIT_DEPTH = csw_pkg::WAIT_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  csw_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output csw_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [csw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [csw_pkg::REG_W-1:0]      cfg_wdata_i
);

  csw_pkg::ctrl_cmd_t  cmd;
  csw_pkg::dp_status_t dp_status;

  csw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  csw_dp #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (dp_status)
  );

endmodule

[sv/csw_checker.sv]
// ----------------------------------------------------------------------------
// csw_checker
// Port-level checks of the semaphore, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input csw_pkg::out_item_t  out_item_o
);

  // A wake only comes with a successful release
  `ASSERT_IMPL(a_wake_on_release, clk_i, rst_ni, out_valid_o && out_item_o.wake_valid, out_item_o.status == csw_pkg::ST_RELEASED)

  // No wake, no task id
  `ASSERT_IMPL(a_wake_task_zero, clk_i, rst_ni, out_valid_o && !out_item_o.wake_valid, out_item_o.wake_task == '0)

  // A blocked task leaves the count negative
  `ASSERT_IMPL(a_blocked_negative, clk_i, rst_ni, out_valid_o && (out_item_o.status == csw_pkg::ST_BLOCKED), out_item_o.count_after[csw_pkg::OUT_COUNT_W-1])

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind counting_semaphore_wait_queue csw_checker u_csw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the counting semaphore with a FIFO wait queue.
// A short scripted sequence covers binary mode, the wake path, a full wait
// queue, a zero ceiling and the register extremes; randomized phases follow,
// each under its own ceiling and acquire/release mix, most with a new start
// count. Results are checked field by field against typed-in or model values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import csw_pkg::*;

  localparam int DEPTH       = csw_pkg::WAIT_DEPTH;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 75;
  localparam int IDLE_PCT    = 37;

  // One scripted step: an item (result typed in or modeled) or a register write
  typedef struct {
    bit                 is_cfg;
    cfg_idx_e           reg_idx;
    logic [REG_W-1:0]   reg_val;
    in_item_t           item;
    bit                 known;
    out_item_t          result;
  } plan_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]   cfg_wdata_i = '0;

  // Semaphore model state
  logic [REG_W-1:0]         ceil_reg = 15'd1;
  int                       sem_cnt  = 1;
  logic [TASK_ID_WIDTH-1:0] waiters [DEPTH];
  int                       head     = 0;
  int                       fill     = 0;

  out_item_t  due_q [$];
  plan_row_t  plan_q [$];
  int         fail_cnt = 0;
  bit         calm     = 1'b0;

  counting_semaphore_wait_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one operation to the model and return its result
  function automatic out_item_t sem_step(in_item_t it);
    out_item_t r;
    r.wake_valid = 1'b0;
    r.wake_task  = '0;
    if (it.op == OP_ACQUIRE) begin
      if (sem_cnt - 1 < 0) begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          waiters[(head + fill) % DEPTH] = it.task_id;
          fill++;
          sem_cnt--;
          r.status = ST_BLOCKED;
        end
      end else begin
        sem_cnt--;
        r.status = ST_GRANTED;
      end
    end else if (sem_cnt < int'(ceil_reg)) begin
      sem_cnt++;
      r.status = ST_RELEASED;
      // hand the count to the oldest waiter while there is a deficit
      if (sem_cnt <= 0 && fill > 0) begin
        r.wake_valid = 1'b1;
        r.wake_task  = waiters[head];
        head = (head + 1) % DEPTH;
        fill--;
      end
    end else begin
      r.status = ST_IGNORED;
    end
    r.count_after = 16'(sem_cnt);
    return r;
  endfunction

  // Empty plan row
  function automatic plan_row_t blank_row();
    plan_row_t row;
    row.is_cfg  = 1'b0;
    row.reg_idx = CFG_MAX_COUNT;
    row.reg_val = '0;
    row.item    = '0;
    row.known   = 1'b0;
    row.result  = '0;
    return row;
  endfunction

  function automatic void add_op(op_e op, logic [TASK_ID_WIDTH-1:0] tid);
    plan_row_t row;
    row = blank_row();
    row.item.op      = op;
    row.item.task_id = tid;
    plan_q.push_back(row);
  endfunction

  function automatic void add_known(op_e op, logic [TASK_ID_WIDTH-1:0] tid, status_e st,
                                    logic wv, logic [TASK_ID_WIDTH-1:0] wt, int cnt);
    plan_row_t row;
    row = blank_row();
    row.item.op            = op;
    row.item.task_id       = tid;
    row.known              = 1'b1;
    row.result.status      = st;
    row.result.wake_valid  = wv;
    row.result.wake_task   = wt;
    row.result.count_after = 16'(cnt);
    plan_q.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [REG_W-1:0] val);
    plan_row_t row;
    row = blank_row();
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan_q.push_back(row);
  endfunction

  // Register value spread: mostly small, with both extremes
  function automatic logic [REG_W-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return 15'd1;
      2: return 15'($urandom_range(2, 4));
      3: return 15'($urandom_range(2, 4));
      4: return 15'($urandom_range(5, 40));
      5: return '1;
      6: return 15'($urandom_range(32767));
      default: return 15'($urandom_range(1, 3));
    endcase
  endfunction

  // Present one item, hold it until taken, then log what it should produce
  task automatic send_item(in_item_t it, bit known, out_item_t typed);
    out_item_t pred;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = sem_step(it);
    due_q.push_back(known ? typed : pred);
  endtask

  // Register write, only once every pending result has drained
  task automatic write_reg(cfg_idx_e idx, logic [REG_W-1:0] val);
    in_valid_i <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_COUNT) begin
      ceil_reg = val;
    end else begin
      sem_cnt = int'(val);
      head    = 0;
      fill    = 0;
    end
    @(posedge clk_i);
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_q.size() == 0) begin
        $error("result with no item outstanding: status=%0d count_after=%0d",
               out_item_o.status, out_item_o.count_after);
        fail_cnt++;
      end else begin
        want = due_q.pop_front();
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item_o.status);
          fail_cnt++;
        end
        if (out_item_o.wake_valid !== want.wake_valid) begin
          $error("wake_valid: expected %0d, actual %0d", want.wake_valid,
                 out_item_o.wake_valid);
          fail_cnt++;
        end
        if (out_item_o.wake_task !== want.wake_task) begin
          $error("wake_task: expected %0d, actual %0d", want.wake_task,
                 out_item_o.wake_task);
          fail_cnt++;
        end
        if (out_item_o.count_after !== want.count_after) begin
          $error("count_after: expected %0d, actual %0d", want.count_after,
                 out_item_o.count_after);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t none;
    int        acq_pct;
    int        calm_phase;

    none = '0;

    // Binary mode straight out of reset
    add_known(OP_ACQUIRE, 8'h00, ST_GRANTED,  1'b0, 8'h00, 0);
    add_known(OP_ACQUIRE, 8'hFF, ST_BLOCKED,  1'b0, 8'h00, -1);
    add_known(OP_RELEASE, 8'h00, ST_RELEASED, 1'b1, 8'hFF, 0);
    add_known(OP_RELEASE, 8'h00, ST_RELEASED, 1'b0, 8'h00, 1);
    // Zero ceiling below the current count: release is ignored, count stays
    add_cfg(CFG_MAX_COUNT, 15'd0);
    add_known(OP_RELEASE, 8'hFF, ST_IGNORED,  1'b0, 8'h00, 1);
    // Reload to zero, then fill the wait queue and overflow it
    add_cfg(CFG_INITIAL_COUNT, 15'd0);
    for (int k = 0; k < DEPTH; k++) add_op(OP_ACQUIRE, 8'(k * 17));
    add_known(OP_ACQUIRE, 8'h3C, ST_FULL,     1'b0, 8'h00, -16);
    // Zero ceiling still lets a negative count rise and wake the oldest
    add_known(OP_RELEASE, 8'h00, ST_RELEASED, 1'b1, 8'h00, -15);
    // Register extremes
    add_cfg(CFG_MAX_COUNT, '1);
    add_cfg(CFG_INITIAL_COUNT, '1);
    add_known(OP_RELEASE, 8'h00, ST_IGNORED,  1'b0, 8'h00, 32767);
    add_known(OP_ACQUIRE, 8'hC3, ST_GRANTED,  1'b0, 8'h00, 32766);
    add_known(OP_RELEASE, 8'h00, ST_RELEASED, 1'b0, 8'h00, 32767);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted part
    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
      else send_item(plan_q[i].item, plan_q[i].known, plan_q[i].result);
    end

    // Randomized phases, one of them with no idling on either side
    calm_phase = $urandom_range(2, PHASES - 2);
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_MAX_COUNT, pick_level());
      if ($urandom_range(3) != 0) write_reg(CFG_INITIAL_COUNT, pick_level());
      calm <= (ph == calm_phase);
      case ($urandom_range(3))
        0:       acq_pct = 25;
        1:       acq_pct = 50;
        2:       acq_pct = 60;
        default: acq_pct = 75;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.op      = ($urandom_range(99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
        it.task_id = 8'($urandom_range(255));
        send_item(it, 1'b0, none);
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    calm       <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
